// ===== hw/rtl/sha_pkg.sv =====
// package: sizes, codes and helpers used by the hole allocator top level
`default_nettype none
package sha_pkg;

  localparam int ADDR_BITS  = 16;
  localparam int HOLES      = 16;
  localparam int SEGMENTS   = 32;
  localparam int TAG_BITS   = 8;

  localparam int LEN_W      = ADDR_BITS + 1;
  localparam int MEM_SIZE_W = 17;
  localparam int MEM_CAP    = 2 ** ADDR_BITS;
  localparam int HIDX_W     = $clog2(HOLES);
  localparam int CNT_W      = $clog2(HOLES + 2);
  localparam int SIDX_W     = $clog2(SEGMENTS);
  localparam int SCNT_W     = $clog2(SEGMENTS + 1);
  localparam int BANKS      = 4;
  localparam int BANK_W     = 2;
  localparam int HOLE_W     = ADDR_BITS + LEN_W;
  localparam int SEG_W      = ADDR_BITS + LEN_W + TAG_BITS;

  localparam logic [2:0] ACT_ADD      = 3'd0;
  localparam logic [2:0] ACT_ALLOC    = 3'd1;
  localparam logic [2:0] ACT_FREE     = 3'd2;
  localparam logic [2:0] ACT_FREE_TAG = 3'd3;
  localparam logic [2:0] ACT_COMMIT   = 3'd4;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_NOFIT = 3'd1;
  localparam logic [2:0] ST_FULL  = 3'd2;
  localparam logic [2:0] ST_MISS  = 3'd3;
  localparam logic [2:0] ST_ZERO  = 3'd4;

  typedef logic [BANK_W-1:0] bank_t;

  // end of a hole clipped to the memory limit
  function automatic logic [LEN_W-1:0] clip_hi(input logic [ADDR_BITS-1:0] b,
                                               input logic [LEN_W-1:0] sz,
                                               input logic [LEN_W-1:0] lim);
    logic [LEN_W:0] s;
    s = (LEN_W+1)'(b) + (LEN_W+1)'(sz);
    clip_hi = (s > (LEN_W+1)'(lim)) ? lim : s[LEN_W-1:0];
  endfunction

  // lowest bank that holds neither the live, the source nor the checkpoint table
  function automatic bank_t pick_bank(input bank_t cur, input bank_t src,
                                      input bank_t ck, input logic held);
    pick_bank = '0;
    for (int i = BANKS - 1; i >= 0; i--) begin
      if (BANK_W'(i) != cur && BANK_W'(i) != src && !(held && BANK_W'(i) == ck)) begin
        pick_bank = BANK_W'(i);
      end
    end
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/sha_ram.sv =====
// generic simple dual port ram with registered read
`default_nettype none
module sha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/segment_hole_allocator_top.sv =====
// top level: free hole table and segment table allocator
// usage:
//   input words carry one request (add hole, allocate, free region, free tag,
//   commit); each request gives exactly one result word with status, base of
//   an allocated segment and the hole count afterwards
//   both channels are valid/stall; a word moves when valid is high and stall low
//   memory_size is written through cfg_we/cfg_wdata; the user must write it only
//   while the block is idle, the block itself does not enforce this
//   one request at a time; a hole table pass reads the stored holes one by one
//   through the one read port of the hole ram and writes the new table to a
//   free bank; add hole: one pass, allocate: a hole scan and one pass, free
//   region: a segment scan and at most one pass, free tag: a segment scan and
//   a pass per matching segment in memory (at most 16 holes), commit: no pass
// reset:
//   empty hole table, all segments free, no checkpoint, memory_size 65536;
//   the rams need no clearing since no entry is read before it is written
// stall:
//   a finished result waits in S_DONE until the output register is empty or is
//   being handed over; the next request is taken once the result is in it
`default_nettype none
module segment_hole_allocator_top (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // request channel
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [2:0]                   in_action,
  input  wire logic                         in_fit_policy,
  input  wire logic [sha_pkg::TAG_BITS-1:0] in_process_tag,
  input  wire logic [sha_pkg::ADDR_BITS-1:0] in_base_addr,
  input  wire logic [sha_pkg::LEN_W-1:0]    in_seg_size,
  input  wire logic                         in_first_of_process,
  // result channel
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [2:0]                        out_status,
  output logic [sha_pkg::ADDR_BITS-1:0]     out_seg_base,
  output logic [sha_pkg::CNT_W-1:0]         out_hole_count,
  // configuration
  input  wire logic                         cfg_we,
  input  wire logic [sha_pkg::MEM_SIZE_W-1:0] cfg_wdata
);
  import sha_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE     = 11'b00000000001,
    S_ALLOC    = 11'b00000000010,
    S_HSCAN_RD = 11'b00000000100,
    S_HSCAN_EV = 11'b00000001000,
    S_PASS_RD  = 11'b00000010000,
    S_PASS_EV  = 11'b00000100000,
    S_PASS_END = 11'b00001000000,
    S_SSCAN_RD = 11'b00010000000,
    S_SSCAN_EV = 11'b00100000000,
    S_SEND     = 11'b01000000000,
    S_DONE     = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;

  // request fields
  logic [2:0]           act_r, act_nxt;
  logic                 best_r, best_nxt;
  logic [TAG_BITS-1:0]  tag_r, tag_nxt;
  logic [ADDR_BITS-1:0] base_r, base_nxt;
  logic [LEN_W-1:0]     size_r, size_nxt;

  // hole table bookkeeping: live bank, checkpoint bank, pass source and target
  bank_t                cur_bank_r, cur_bank_nxt;
  bank_t                ckpt_bank_r, ckpt_bank_nxt;
  logic                 ckpt_held_r, ckpt_held_nxt;
  logic [CNT_W-1:0]     ckpt_used_r, ckpt_used_nxt;
  logic [CNT_W-1:0]     used_r, used_nxt;
  bank_t                src_bank_r, src_bank_nxt;
  bank_t                dst_bank_r, dst_bank_nxt;
  logic [CNT_W-1:0]     src_used_r, src_used_nxt;

  // pass and scan state
  logic [CNT_W-1:0]     hidx_r, hidx_nxt;
  logic [SCNT_W-1:0]    sidx_r, sidx_nxt;
  logic [CNT_W-1:0]     k_r, k_nxt;
  logic [CNT_W-1:0]     kept_r, kept_nxt;
  logic                 ins_r, ins_nxt;
  logic                 merge_r, merge_nxt;
  logic [LEN_W-1:0]     lo_r, lo_nxt;
  logic [LEN_W-1:0]     hi_r, hi_nxt;
  logic [HIDX_W-1:0]    pick_r, pick_nxt;
  logic                 pfound_r, pfound_nxt;
  logic [LEN_W-1:0]     pick_len_r, pick_len_nxt;
  logic [ADDR_BITS-1:0] pick_base_r, pick_base_nxt;
  logic [SIDX_W-1:0]    slot_r, slot_nxt;
  logic                 found_r, found_nxt;
  logic                 full_r, full_nxt;

  // segment flags
  logic [SEGMENTS-1:0]  valid_r, valid_nxt;
  logic [SEGMENTS-1:0]  pend_r, pend_nxt;
  logic [SEGMENTS-1:0]  mask_r, mask_nxt;

  // result
  logic [2:0]           status_r, status_nxt;
  logic [ADDR_BITS-1:0] where_r, where_nxt;
  logic [MEM_SIZE_W-1:0] mem_size_r, mem_size_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [2:0]           out_status_r, out_status_nxt;
  logic [ADDR_BITS-1:0] out_seg_base_r, out_seg_base_nxt;
  logic [CNT_W-1:0]     out_hole_count_r, out_hole_count_nxt;

  // ram ports
  logic                     h_we, h_re;
  logic [BANK_W+HIDX_W-1:0] h_waddr, h_raddr;
  logic [HOLE_W-1:0]        h_wdata, h_rdata;
  logic                     s_we, s_re;
  logic [SIDX_W-1:0]        s_waddr, s_raddr;
  logic [SEG_W-1:0]         s_wdata, s_rdata;

  // hole table: four banks of HOLES entries {base, length}
  sha_ram #(.WIDTH(HOLE_W), .DEPTH(BANKS * HOLES)) u_hole_ram (
    .clk   (clk),
    .we    (h_we),
    .waddr (h_waddr),
    .wdata (h_wdata),
    .re    (h_re),
    .raddr (h_raddr),
    .rdata (h_rdata)
  );

  // segment table: {base, length, owner}
  sha_ram #(.WIDTH(SEG_W), .DEPTH(SEGMENTS)) u_seg_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .re    (s_re),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  // decoded read data
  logic [ADDR_BITS-1:0] hr_base;
  logic [LEN_W-1:0]     hr_len, hr_end, hr_rest;
  logic [ADDR_BITS-1:0] sr_base;
  logic [LEN_W-1:0]     sr_len;
  logic [TAG_BITS-1:0]  sr_owner;

  assign hr_base  = h_rdata[HOLE_W-1:LEN_W];
  assign hr_len   = h_rdata[LEN_W-1:0];
  assign hr_end   = LEN_W'(hr_base) + hr_len;
  assign hr_rest  = hr_len - size_r;
  assign sr_base  = s_rdata[SEG_W-1:LEN_W+TAG_BITS];
  assign sr_len   = s_rdata[LEN_W+TAG_BITS-1:TAG_BITS];
  assign sr_owner = s_rdata[TAG_BITS-1:0];

  // memory limit and clipped hole ends
  logic [LEN_W-1:0] lim;
  logic [LEN_W-1:0] in_hi, base_hi, seg_hi;
  logic             in_empty, base_empty, seg_empty;

  assign lim        = (mem_size_r > MEM_SIZE_W'(MEM_CAP)) ? LEN_W'(MEM_CAP)
                                                          : LEN_W'(mem_size_r);
  assign in_hi      = clip_hi(in_base_addr, in_seg_size, lim);
  assign in_empty   = LEN_W'(in_base_addr) >= in_hi;
  assign base_hi    = clip_hi(base_r, size_r, lim);
  assign base_empty = LEN_W'(base_r) >= base_hi;
  assign seg_hi     = clip_hi(sr_base, sr_len, lim);
  assign seg_empty  = LEN_W'(sr_base) >= seg_hi;

  bank_t dst_cur, dst_src;
  assign dst_cur = pick_bank(cur_bank_r, cur_bank_r, ckpt_bank_r, ckpt_held_r);
  assign dst_src = pick_bank(cur_bank_r, src_bank_r, ckpt_bank_r, ckpt_held_r);

  // lowest free segment slot
  logic              free_any;
  logic [SIDX_W-1:0] free_idx;
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = SEGMENTS - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_any = 1'b1;
        free_idx = SIDX_W'(i);
      end
    end
  end

  // last insertion of a merge pass
  logic             tail_ins;
  logic [CNT_W-1:0] k_fin;
  logic             pass_full;
  assign tail_ins  = merge_r && !ins_r;
  assign k_fin     = k_r + CNT_W'(tail_ins);
  assign pass_full = merge_r && (kept_r == CNT_W'(HOLES));

  always_comb begin
    state_nxt          = state_r;
    act_nxt            = act_r;
    best_nxt           = best_r;
    tag_nxt            = tag_r;
    base_nxt           = base_r;
    size_nxt           = size_r;
    cur_bank_nxt       = cur_bank_r;
    ckpt_bank_nxt      = ckpt_bank_r;
    ckpt_held_nxt      = ckpt_held_r;
    ckpt_used_nxt      = ckpt_used_r;
    used_nxt           = used_r;
    src_bank_nxt       = src_bank_r;
    dst_bank_nxt       = dst_bank_r;
    src_used_nxt       = src_used_r;
    hidx_nxt           = hidx_r;
    sidx_nxt           = sidx_r;
    k_nxt              = k_r;
    kept_nxt           = kept_r;
    ins_nxt            = ins_r;
    merge_nxt          = merge_r;
    lo_nxt             = lo_r;
    hi_nxt             = hi_r;
    pick_nxt           = pick_r;
    pfound_nxt         = pfound_r;
    pick_len_nxt       = pick_len_r;
    pick_base_nxt      = pick_base_r;
    slot_nxt           = slot_r;
    found_nxt          = found_r;
    full_nxt           = full_r;
    valid_nxt          = valid_r;
    pend_nxt           = pend_r;
    mask_nxt           = mask_r;
    status_nxt         = status_r;
    where_nxt          = where_r;
    mem_size_nxt       = mem_size_r;
    out_valid_nxt      = out_valid_r;
    out_status_nxt     = out_status_r;
    out_seg_base_nxt   = out_seg_base_r;
    out_hole_count_nxt = out_hole_count_r;

    h_we    = 1'b0;
    h_waddr = {dst_bank_r, k_r[HIDX_W-1:0]};
    h_wdata = h_rdata;
    h_re    = 1'b0;
    h_raddr = {src_bank_r, hidx_r[HIDX_W-1:0]};
    s_we    = 1'b0;
    s_waddr = slot_r;
    s_wdata = {pick_base_r, size_r, tag_r};
    s_re    = 1'b0;
    s_raddr = sidx_r[SIDX_W-1:0];

    if (cfg_we) begin
      mem_size_nxt = cfg_wdata;
    end
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          act_nxt      = in_action;
          best_nxt     = in_fit_policy;
          tag_nxt      = in_process_tag;
          base_nxt     = in_base_addr;
          size_nxt     = in_seg_size;
          status_nxt   = ST_MISS;
          where_nxt    = '0;
          src_bank_nxt = cur_bank_r;
          src_used_nxt = used_r;
          dst_bank_nxt = dst_cur;
          hidx_nxt     = '0;
          k_nxt        = '0;
          kept_nxt     = '0;
          ins_nxt      = 1'b0;
          merge_nxt    = 1'b1;
          sidx_nxt     = '0;
          found_nxt    = 1'b0;
          full_nxt     = 1'b0;
          mask_nxt     = '0;
          priority if (in_action <= ACT_FREE && in_seg_size == '0) begin
            status_nxt = ST_ZERO;
            state_nxt  = S_DONE;
          end else if (in_action == ACT_ADD) begin
            lo_nxt    = LEN_W'(in_base_addr);
            hi_nxt    = in_hi;
            state_nxt = in_empty ? S_DONE : S_PASS_RD;
          end else if (in_action == ACT_ALLOC) begin
            // first segment: commit earlier ones and snapshot the live bank
            if (in_first_of_process) begin
              pend_nxt      = '0;
              ckpt_bank_nxt = cur_bank_r;
              ckpt_used_nxt = used_r;
              ckpt_held_nxt = 1'b1;
            end
            state_nxt = S_ALLOC;
          end else if (in_action == ACT_FREE || in_action == ACT_FREE_TAG) begin
            state_nxt = S_SSCAN_RD;
          end else if (in_action == ACT_COMMIT) begin
            pend_nxt      = '0;
            ckpt_held_nxt = 1'b0;
            status_nxt    = ST_OK;
            state_nxt     = S_DONE;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end

      S_ALLOC: begin
        if (!free_any) begin
          if (ckpt_held_r) begin
            cur_bank_nxt = ckpt_bank_r;
            used_nxt     = ckpt_used_r;
          end
          valid_nxt  = valid_r & ~pend_r;
          pend_nxt   = '0;
          status_nxt = ST_FULL;
          state_nxt  = S_DONE;
        end else begin
          slot_nxt   = free_idx;
          hidx_nxt   = '0;
          pfound_nxt = 1'b0;
          state_nxt  = S_HSCAN_RD;
        end
      end

      S_HSCAN_RD: begin
        if (hidx_r < used_r) begin
          h_re      = 1'b1;
          state_nxt = S_HSCAN_EV;
        end else if (!pfound_r) begin
          if (ckpt_held_r) begin
            cur_bank_nxt = ckpt_bank_r;
            used_nxt     = ckpt_used_r;
          end
          valid_nxt  = valid_r & ~pend_r;
          pend_nxt   = '0;
          status_nxt = ST_NOFIT;
          state_nxt  = S_DONE;
        end else begin
          // copy the live bank with the picked hole trimmed
          merge_nxt    = 1'b0;
          hidx_nxt     = '0;
          k_nxt        = '0;
          kept_nxt     = '0;
          src_bank_nxt = cur_bank_r;
          src_used_nxt = used_r;
          dst_bank_nxt = dst_cur;
          state_nxt    = S_PASS_RD;
        end
      end

      S_HSCAN_EV: begin
        if (hr_len >= size_r && (!pfound_r || (best_r && hr_len < pick_len_r))) begin
          pick_nxt      = hidx_r[HIDX_W-1:0];
          pick_len_nxt  = hr_len;
          pick_base_nxt = hr_base;
          pfound_nxt    = 1'b1;
        end
        hidx_nxt  = hidx_r + 1'b1;
        state_nxt = S_HSCAN_RD;
      end

      S_PASS_RD: begin
        if (hidx_r < src_used_r) begin
          h_re      = 1'b1;
          state_nxt = S_PASS_EV;
        end else begin
          state_nxt = S_PASS_END;
        end
      end

      S_PASS_EV: begin
        if (merge_r) begin
          priority if (LEN_W'(hr_base) <= hi_r && hr_end >= lo_r) begin
            // touching or overlapping: absorb
            if (LEN_W'(hr_base) < lo_r) lo_nxt = LEN_W'(hr_base);
            if (hr_end > hi_r) hi_nxt = hr_end;
            hidx_nxt  = hidx_r + 1'b1;
            state_nxt = S_PASS_RD;
          end else if (LEN_W'(hr_base) < lo_r) begin
            h_we      = k_r < CNT_W'(HOLES);
            k_nxt     = k_r + 1'b1;
            kept_nxt  = kept_r + 1'b1;
            hidx_nxt  = hidx_r + 1'b1;
            state_nxt = S_PASS_RD;
          end else if (!ins_r) begin
            // new hole goes ahead of this one; entry is kept for the next cycle
            h_we    = k_r < CNT_W'(HOLES);
            h_wdata = {lo_r[ADDR_BITS-1:0], hi_r - lo_r};
            k_nxt   = k_r + 1'b1;
            ins_nxt = 1'b1;
          end else begin
            h_we      = k_r < CNT_W'(HOLES);
            k_nxt     = k_r + 1'b1;
            kept_nxt  = kept_r + 1'b1;
            hidx_nxt  = hidx_r + 1'b1;
            state_nxt = S_PASS_RD;
          end
        end else begin
          if (hidx_r[HIDX_W-1:0] == pick_r) begin
            if (hr_rest != '0) begin
              h_we    = 1'b1;
              h_wdata = {ADDR_BITS'(LEN_W'(hr_base) + size_r), hr_rest};
              k_nxt   = k_r + 1'b1;
            end
          end else begin
            h_we  = 1'b1;
            k_nxt = k_r + 1'b1;
          end
          hidx_nxt  = hidx_r + 1'b1;
          state_nxt = S_PASS_RD;
        end
      end

      S_PASS_END: begin
        if (tail_ins) begin
          h_we    = k_r < CNT_W'(HOLES);
          h_wdata = {lo_r[ADDR_BITS-1:0], hi_r - lo_r};
        end
        priority if (act_r == ACT_ALLOC) begin
          cur_bank_nxt    = dst_bank_r;
          used_nxt        = k_fin;
          s_we            = 1'b1;
          valid_nxt[slot_r] = 1'b1;
          pend_nxt[slot_r]  = 1'b1;
          where_nxt       = pick_base_r;
          status_nxt      = ST_OK;
          state_nxt       = S_DONE;
        end else if (act_r == ACT_FREE_TAG) begin
          // accumulate into the scratch table, resume the segment scan
          if (pass_full) begin
            full_nxt = 1'b1;
          end else begin
            src_bank_nxt = dst_bank_r;
            src_used_nxt = k_fin;
          end
          sidx_nxt  = sidx_r + 1'b1;
          state_nxt = S_SSCAN_RD;
        end else begin
          if (pass_full) begin
            status_nxt = ST_FULL;
          end else begin
            cur_bank_nxt = dst_bank_r;
            used_nxt     = k_fin;
            status_nxt   = ST_OK;
            if (act_r == ACT_FREE) begin
              valid_nxt[slot_r] = 1'b0;
              pend_nxt[slot_r]  = 1'b0;
            end
          end
          state_nxt = S_DONE;
        end
      end

      S_SSCAN_RD: begin
        if (sidx_r == SCNT_W'(SEGMENTS)) begin
          state_nxt = S_SEND;
        end else if (valid_r[sidx_r[SIDX_W-1:0]]) begin
          s_re      = 1'b1;
          state_nxt = S_SSCAN_EV;
        end else begin
          sidx_nxt = sidx_r + 1'b1;
        end
      end

      S_SSCAN_EV: begin
        hidx_nxt     = '0;
        k_nxt        = '0;
        kept_nxt     = '0;
        ins_nxt      = 1'b0;
        merge_nxt    = 1'b1;
        dst_bank_nxt = dst_src;
        if (act_r == ACT_FREE) begin
          if (sr_base == base_r) begin
            found_nxt = 1'b1;
            slot_nxt  = sidx_r[SIDX_W-1:0];
            if (base_empty) begin
              // region lies outside memory: segment freed, holes unchanged
              valid_nxt[sidx_r[SIDX_W-1:0]] = 1'b0;
              pend_nxt[sidx_r[SIDX_W-1:0]]  = 1'b0;
              status_nxt = ST_OK;
              state_nxt  = S_DONE;
            end else begin
              lo_nxt    = LEN_W'(base_r);
              hi_nxt    = base_hi;
              state_nxt = S_PASS_RD;
            end
          end else begin
            sidx_nxt  = sidx_r + 1'b1;
            state_nxt = S_SSCAN_RD;
          end
        end else begin
          if (sr_owner == tag_r) begin
            found_nxt                     = 1'b1;
            mask_nxt[sidx_r[SIDX_W-1:0]] = 1'b1;
            if (seg_empty) begin
              sidx_nxt  = sidx_r + 1'b1;
              state_nxt = S_SSCAN_RD;
            end else begin
              lo_nxt    = LEN_W'(sr_base);
              hi_nxt    = seg_hi;
              state_nxt = S_PASS_RD;
            end
          end else begin
            sidx_nxt  = sidx_r + 1'b1;
            state_nxt = S_SSCAN_RD;
          end
        end
      end

      S_SEND: begin
        if (!found_r) begin
          status_nxt = ST_MISS;
        end else if (full_r) begin
          status_nxt = ST_FULL;
        end else begin
          cur_bank_nxt = src_bank_r;
          used_nxt     = src_used_r;
          valid_nxt    = valid_r & ~mask_r;
          pend_nxt     = pend_r & ~mask_r;
          status_nxt   = ST_OK;
        end
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt      = 1'b1;
          out_status_nxt     = status_r;
          out_seg_base_nxt   = where_r;
          out_hole_count_nxt = used_r;
          state_nxt          = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cur_bank_r  <= '0;
      ckpt_bank_r <= '0;
      ckpt_held_r <= 1'b0;
      ckpt_used_r <= '0;
      used_r      <= '0;
      valid_r     <= '0;
      pend_r      <= '0;
      mem_size_r  <= MEM_SIZE_W'(65536);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_bank_r  <= cur_bank_nxt;
      ckpt_bank_r <= ckpt_bank_nxt;
      ckpt_held_r <= ckpt_held_nxt;
      ckpt_used_r <= ckpt_used_nxt;
      used_r      <= used_nxt;
      valid_r     <= valid_nxt;
      pend_r      <= pend_nxt;
      mem_size_r  <= mem_size_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    act_r            <= act_nxt;
    best_r           <= best_nxt;
    tag_r            <= tag_nxt;
    base_r           <= base_nxt;
    size_r           <= size_nxt;
    src_bank_r       <= src_bank_nxt;
    dst_bank_r       <= dst_bank_nxt;
    src_used_r       <= src_used_nxt;
    hidx_r           <= hidx_nxt;
    sidx_r           <= sidx_nxt;
    k_r              <= k_nxt;
    kept_r           <= kept_nxt;
    ins_r            <= ins_nxt;
    merge_r          <= merge_nxt;
    lo_r             <= lo_nxt;
    hi_r             <= hi_nxt;
    pick_r           <= pick_nxt;
    pfound_r         <= pfound_nxt;
    pick_len_r       <= pick_len_nxt;
    pick_base_r      <= pick_base_nxt;
    slot_r           <= slot_nxt;
    found_r          <= found_nxt;
    full_r           <= full_nxt;
    mask_r           <= mask_nxt;
    status_r         <= status_nxt;
    where_r          <= where_nxt;
    out_status_r     <= out_status_nxt;
    out_seg_base_r   <= out_seg_base_nxt;
    out_hole_count_r <= out_hole_count_nxt;
  end

  assign in_stall       = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_seg_base   = out_seg_base_r;
  assign out_hole_count = out_hole_count_r;

endmodule
`default_nettype wire
